// ----- rtl/cwmf_pkg.sv -----
// Shared constants, register indexes and pipeline control struct of the color median filter.
package cwmf_pkg;

  // Default build sizes
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_RADIUS   = 3;
  localparam int DEF_CHANNEL_BITS = 8;

  // Fixed field widths
  localparam int CFG_BITS    = 11;
  localparam int INDEX_BITS  = 2;
  localparam int RCFG_BITS   = 2;
  localparam int RAD_BITS    = 3;   // holds a clamped radius up to 7
  localparam int RANK_BITS   = 7;   // holds ranks of up to 81 elements
  localparam int CENTER_BITS = 10;
  localparam int CNT_BITS    = 13;  // wide enough for size compares

  // Register indexes
  localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [INDEX_BITS-1:0] REG_KERNEL_RADIUS = 2'd2;

  // Control that travels with an item down the rank chain
  typedef struct packed {
    logic                   valid;
    logic [RAD_BITS-1:0]    radius;
    logic [RANK_BITS-1:0]   mid;
    logic [CENTER_BITS-1:0] crow;
    logic [CENTER_BITS-1:0] ccol;
  } meta_t;

endpackage

// ----- rtl/color_window_median_filter.sv -----
// Top level of the streaming color median filter over a square window.
//
// Takes one RGBA pixel per clock while not stalled, in raster order, and,
// for every window centered on an interior pixel, returns the window element
// of middle rank by key red+green+blue (ties broken by position, row by row);
// border pixels give no result. The rate is set by the line store: one bank
// per stored row, each read once per pixel at the current column, and only
// the bank of the current row slot written. Before out_valid rises for a
// result, it passes the read stage, window stage, one rank cell per window
// row, then a two-entry output buffer that lets input continue while a
// result waits. Input stalls only when that buffer is full. The line store
// has no clearing pass; the first rows of a frame after reset fill it.
module color_window_median_filter #(
  parameter int MAX_WIDTH    = cwmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = cwmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS   = cwmf_pkg::DEF_MAX_RADIUS,
  parameter int CHANNEL_BITS = cwmf_pkg::DEF_CHANNEL_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [cwmf_pkg::INDEX_BITS-1:0]  cfg_index,
  input  logic [cwmf_pkg::CFG_BITS-1:0]    cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [CHANNEL_BITS-1:0]          in_red_in,
  input  logic [CHANNEL_BITS-1:0]          in_green_in,
  input  logic [CHANNEL_BITS-1:0]          in_blue_in,
  input  logic [CHANNEL_BITS-1:0]          in_alpha_in,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [CHANNEL_BITS-1:0]          out_red_out,
  output logic [CHANNEL_BITS-1:0]          out_green_out,
  output logic [CHANNEL_BITS-1:0]          out_blue_out,
  output logic [CHANNEL_BITS-1:0]          out_alpha_out,
  output logic [cwmf_pkg::CENTER_BITS-1:0] out_center_row,
  output logic [cwmf_pkg::CENTER_BITS-1:0] out_center_col
);

  localparam int LINES = 2 * MAX_RADIUS;
  localparam int SIDE  = LINES + 1;
  localparam int N     = SIDE * SIDE;
  localparam int PW    = 4 * CHANNEL_BITS;
  localparam int KW    = CHANNEL_BITS + 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RWB   = $clog2(MAX_HEIGHT);
  localparam int SW    = $clog2(LINES);
  localparam int CB    = cwmf_pkg::CNT_BITS;
  localparam int RB    = cwmf_pkg::RANK_BITS;
  localparam int CTB   = cwmf_pkg::CENTER_BITS;

  logic [cwmf_pkg::CFG_BITS-1:0]  img_w_r, img_h_r;
  logic [cwmf_pkg::RCFG_BITS-1:0] rad_r;
  logic [CW-1:0]  col_r;
  logic [RWB-1:0] row_r;
  logic [SW-1:0]  slot_r;

  logic [CB-1:0] w_raw, h_raw, w_eff, h_eff, col_e, row_e, two_r;
  logic [cwmf_pkg::RAD_BITS-1:0] r_eff;
  logic [RB-1:0] r7, mid;
  logic          emit, acc, en;
  logic [PW-1:0] pix;

  cwmf_pkg::meta_t meta1_r, meta2_r, meta_in;
  logic [PW-1:0]   win [N];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= cwmf_pkg::CFG_BITS'(1024);
      img_h_r <= cwmf_pkg::CFG_BITS'(1024);
      rad_r   <= cwmf_pkg::RCFG_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cwmf_pkg::REG_IMAGE_WIDTH:   img_w_r <= cfg_wdata;
        cwmf_pkg::REG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata;
        cwmf_pkg::REG_KERNEL_RADIUS: rad_r   <= cfg_wdata[cwmf_pkg::RCFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and radius
  always_comb begin
    w_raw = CB'(img_w_r);
    h_raw = CB'(img_h_r);
    w_eff = (w_raw == '0) ? CB'(1) : ((w_raw > CB'(MAX_WIDTH)) ? CB'(MAX_WIDTH) : w_raw);
    h_eff = (h_raw == '0) ? CB'(1) : ((h_raw > CB'(MAX_HEIGHT)) ? CB'(MAX_HEIGHT) : h_raw);
    r_eff = (cwmf_pkg::RAD_BITS'(rad_r) > cwmf_pkg::RAD_BITS'(MAX_RADIUS)) ?
            cwmf_pkg::RAD_BITS'(MAX_RADIUS) : cwmf_pkg::RAD_BITS'(rad_r);
    r7    = RB'(r_eff);
    mid   = RB'((r7 * (r7 + RB'(1))) << 1);
    col_e = CB'(col_r);
    row_e = CB'(row_r);
    two_r = CB'(r_eff) << 1;
    emit  = (row_e >= two_r) && (col_e >= two_r) && (row_e < h_eff) && (col_e < w_eff);
  end

  assign pix = {in_alpha_in, in_blue_in, in_green_in, in_red_in};
  assign acc = in_valid && !in_stall;

  // Raster position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (acc) begin
      if (col_e + CB'(1) >= w_eff) begin
        col_r <= '0;
        if (row_e + CB'(1) >= h_eff) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= RWB'(row_e + CB'(1));
          slot_r <= (slot_r == SW'(LINES - 1)) ? '0 : slot_r + SW'(1);
        end
      end else begin
        col_r <= CW'(col_e + CB'(1));
      end
    end
  end

  // Item control for the read and window stages
  always_comb begin
    meta_in.valid  = acc && emit;
    meta_in.radius = r_eff;
    meta_in.mid    = mid;
    meta_in.crow   = CTB'(row_e - CB'(r_eff));
    meta_in.ccol   = CTB'(col_e - CB'(r_eff));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta1_r <= '0;
      meta2_r <= '0;
    end else if (en) begin
      meta1_r <= meta_in;
      meta2_r <= meta1_r;
    end
  end

  cwmf_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .PW         (PW)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .acc   (acc),
    .col   (col_r),
    .slot  (slot_r),
    .pix   (pix),
    .win   (win)
  );

  // Rank chain: one cell per window row
  cwmf_pkg::meta_t meta_c [SIDE+1];
  logic [PW-1:0]   val_c  [SIDE+1][N];
  logic [KW-1:0]   key_c  [SIDE+1][N];
  logic [N-1:0]    act_c  [SIDE+1];
  logic [RB-1:0]   rank_c [SIDE+1][N];

  cwmf_pkg::meta_t meta_h;
  logic [PW-1:0]   val_h  [N];
  logic [KW-1:0]   key_h  [N];
  logic [N-1:0]    act_h;
  logic [RB-1:0]   rank_h [N];

  // Chain head: keys and active mask of the sub-window for this radius
  always_comb begin
    int base;
    base = LINES - 2 * int'(meta2_r.radius);
    meta_h = meta2_r;
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        act_h[i*SIDE+j] = (i >= base) && (j >= base);
      end
    end
    for (int a = 0; a < N; a++) begin
      val_h[a]  = win[a];
      key_h[a]  = KW'(win[a][CHANNEL_BITS-1:0]) +
                  KW'(win[a][2*CHANNEL_BITS-1:CHANNEL_BITS]) +
                  KW'(win[a][3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
      rank_h[a] = '0;
    end
  end

  assign meta_c[0] = meta_h;
  assign val_c[0]  = val_h;
  assign key_c[0]  = key_h;
  assign act_c[0]  = act_h;
  assign rank_c[0] = rank_h;

  for (genvar k = 0; k < SIDE; k++) begin : g_cell
    cwmf_rank_cell #(
      .SIDE (SIDE),
      .ROW  (k),
      .PW   (PW),
      .KW   (KW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .meta_i (meta_c[k]),
      .val_i  (val_c[k]),
      .key_i  (key_c[k]),
      .act_i  (act_c[k]),
      .rank_i (rank_c[k]),
      .meta_o (meta_c[k+1]),
      .val_o  (val_c[k+1]),
      .key_o  (key_c[k+1]),
      .act_o  (act_c[k+1]),
      .rank_o (rank_c[k+1])
    );
  end

  // Pick the element whose rank is the middle one
  logic [PW-1:0] sel_pix;
  always_comb begin
    sel_pix = '0;
    for (int a = 0; a < N; a++) begin
      if (act_c[SIDE][a] && (rank_c[SIDE][a] == meta_c[SIDE].mid)) begin
        sel_pix = sel_pix | val_c[SIDE][a];
      end
    end
  end

  // Two-entry output buffer
  logic [PW-1:0]  fifo_pix_r [2];
  logic [CTB-1:0] fifo_row_r [2];
  logic [CTB-1:0] fifo_col_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;
  assign push     = en && meta_c[SIDE].valid;
  assign out_valid = (cnt_r != 2'd0);
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_pix_r[wp_r] <= sel_pix;
      fifo_row_r[wp_r] <= meta_c[SIDE].crow;
      fifo_col_r[wp_r] <= meta_c[SIDE].ccol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_red_out    = fifo_pix_r[rp_r][CHANNEL_BITS-1:0];
  assign out_green_out  = fifo_pix_r[rp_r][2*CHANNEL_BITS-1:CHANNEL_BITS];
  assign out_blue_out   = fifo_pix_r[rp_r][3*CHANNEL_BITS-1:2*CHANNEL_BITS];
  assign out_alpha_out  = fifo_pix_r[rp_r][4*CHANNEL_BITS-1:3*CHANNEL_BITS];
  assign out_center_row = fifo_row_r[rp_r];
  assign out_center_col = fifo_col_r[rp_r];

endmodule

// ----- rtl/cwmf_window.sv -----
// Line store banks and the square window shift registers.
module cwmf_window #(
  parameter int MAX_WIDTH  = cwmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = cwmf_pkg::DEF_MAX_RADIUS,
  parameter int PW         = 4 * cwmf_pkg::DEF_CHANNEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [$clog2(2*MAX_RADIUS)-1:0] slot,
  input  logic [PW-1:0]                pix,
  output logic [PW-1:0]                win [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)]
);

  localparam int LINES = 2 * MAX_RADIUS;
  localparam int SIDE  = LINES + 1;
  localparam int N     = SIDE * SIDE;
  localparam int SW    = $clog2(LINES);

  logic [PW-1:0] rd_r [LINES];
  logic [PW-1:0] pix1_r;
  logic [SW-1:0] slot1_r;
  logic          v1_r;
  logic [PW-1:0] col_sel [LINES];
  logic [PW-1:0] win_r [N];

  // One bank per stored row: read old data at the column, write the new pixel
  for (genvar s = 0; s < LINES; s++) begin : g_bank
    logic [PW-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        if (slot == SW'(s)) begin
          mem[col] <= pix;
        end
        rd_r[s] <= mem[col];
      end
    end
  end

  // Item registers of the read stage
  always_ff @(posedge clk) begin
    if (acc) begin
      pix1_r  <= pix;
      slot1_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
    end
  end

  // Rotate bank outputs into window rows: row above bottom d comes from slot-d
  always_comb begin
    logic [SW:0] t;
    t = '0;
    for (int d = 1; d <= LINES; d++) begin
      t = (SW+1)'(slot1_r) + (SW+1)'(LINES - d);
      if (t >= (SW+1)'(LINES)) begin
        t = t - (SW+1)'(LINES);
      end
      col_sel[d-1] = rd_r[t[SW-1:0]];
    end
  end

  // Shift window one column left and load the new column
  always_ff @(posedge clk) begin
    if (en && v1_r) begin
      for (int i = 0; i < SIDE; i++) begin
        for (int j = 0; j < SIDE - 1; j++) begin
          win_r[i*SIDE+j] <= win_r[i*SIDE+j+1];
        end
      end
      for (int d = 1; d <= LINES; d++) begin
        win_r[(SIDE-1-d)*SIDE+SIDE-1] <= col_sel[d-1];
      end
      win_r[N-1] <= pix1_r;
    end
  end

  assign win = win_r;

endmodule

// ----- rtl/cwmf_rank_cell.sv -----
// One rank cell: adds to every element's rank its compares against one window row.
module cwmf_rank_cell #(
  parameter int SIDE = 2 * cwmf_pkg::DEF_MAX_RADIUS + 1,
  parameter int ROW  = 0,
  parameter int PW   = 4 * cwmf_pkg::DEF_CHANNEL_BITS,
  parameter int KW   = cwmf_pkg::DEF_CHANNEL_BITS + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  cwmf_pkg::meta_t                meta_i,
  input  logic [PW-1:0]                  val_i  [SIDE*SIDE],
  input  logic [KW-1:0]                  key_i  [SIDE*SIDE],
  input  logic [SIDE*SIDE-1:0]           act_i,
  input  logic [cwmf_pkg::RANK_BITS-1:0] rank_i [SIDE*SIDE],
  output cwmf_pkg::meta_t                meta_o,
  output logic [PW-1:0]                  val_o  [SIDE*SIDE],
  output logic [KW-1:0]                  key_o  [SIDE*SIDE],
  output logic [SIDE*SIDE-1:0]           act_o,
  output logic [cwmf_pkg::RANK_BITS-1:0] rank_o [SIDE*SIDE]
);

  localparam int N = SIDE * SIDE;

  logic [cwmf_pkg::RANK_BITS-1:0] rank_nxt [N];
  cwmf_pkg::meta_t                meta_r;
  logic [PW-1:0]                  val_r  [N];
  logic [KW-1:0]                  key_r  [N];
  logic [N-1:0]                   act_r;
  logic [cwmf_pkg::RANK_BITS-1:0] rank_r [N];

  // Count active row elements that order ahead of each element
  always_comb begin
    logic [cwmf_pkg::RANK_BITS-1:0] cnt;
    cnt = '0;
    for (int a = 0; a < N; a++) begin
      cnt = '0;
      for (int j = 0; j < SIDE; j++) begin
        if (act_i[ROW*SIDE+j] &&
            ((key_i[ROW*SIDE+j] < key_i[a]) ||
             ((key_i[ROW*SIDE+j] == key_i[a]) && (ROW*SIDE+j < a)))) begin
          cnt = cnt + cwmf_pkg::RANK_BITS'(1);
        end
      end
      rank_nxt[a] = rank_i[a] + cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (en) begin
      meta_r <= meta_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r  <= val_i;
      key_r  <= key_i;
      act_r  <= act_i;
      rank_r <= rank_nxt;
    end
  end

  assign meta_o = meta_r;
  assign val_o  = val_r;
  assign key_o  = key_r;
  assign act_o  = act_r;
  assign rank_o = rank_r;

endmodule
